// ===== rtl/core/pbf_pkg.sv =====
// Package for the byte pipe: field widths, action and status codes, defaults.
`timescale 1ns / 1ps

package pbf_pkg;

    // Fixed field widths
    localparam int ACTION_W = 3;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 13;

    // Defaults for top-level parameters
    localparam int DEF_DEPTH    = 4096;
    localparam int DEF_MAX_READ = 64;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_OPEN      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLOSE_RD  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLOSE_WR  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_BLOCK  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_EOF    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BROKEN = 3'd3;
    localparam logic [STATUS_W-1:0] STS_BADF   = 3'd4;

endpackage

// ===== rtl/core/pbf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module pbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pipe_byte_fifo.sv =====
// Top level of the byte pipe: control sequencer, ring pointers and result register.
`timescale 1ns / 1ps

// Byte pipe kept as a ring FIFO of DEPTH bytes in one RAM, with open marks for
// the read end and the write end. Open, write and close beats each give one
// result beat. A read beat that finds data enters a read state, which emits
// up to MAX_READ bytes from the single RAM read port, one byte per cycle while
// the output does not stall; the input stalls until the last byte has been
// loaded into the result register.
// An empty read, a zero-count read and every error give a single result beat.
// One result register parts the two sides: a new beat is taken while a
// finished result still waits, unless the output stalls on a full register.
// The RAM needs no clearing pass; only bytes written since the last open are
// ever read back.
module pipe_byte_fifo #(
    parameter int DEPTH    = pbf_pkg::DEF_DEPTH,
    parameter int MAX_READ = pbf_pkg::DEF_MAX_READ
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [pbf_pkg::ACTION_W-1:0]   i_action,
    input  logic [pbf_pkg::DATA_W-1:0]     i_write_data,
    input  logic [pbf_pkg::COUNT_W-1:0]    i_read_count,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [pbf_pkg::STATUS_W-1:0]   o_status,
    output logic [pbf_pkg::DATA_W-1:0]     o_read_data,
    output logic                           o_data_valid,
    output logic                           o_last,
    output logic [pbf_pkg::LEVEL_W-1:0]    o_fill_level
);

    import pbf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_rd_open, n_rd_open;
    logic                r_wr_open, n_wr_open;
    logic [COUNT_W-1:0]  r_left, n_left;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_rdata, n_rdata;
    logic                r_dvalid, n_dvalid;
    logic                r_last, n_last;
    logic [FW-1:0]       r_level, n_level;

    logic                out_free;
    logic                in_accept;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_rdata;
    logic [COUNT_W-1:0]  want;
    logic [31:0]         level_ext;

    // Ring advance, wrapping at DEPTH (need not be a power of two)
    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        logic [AW-1:0] res;
        if (p == AW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + AW'(1);
        end
        return res;
    endfunction

    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || !out_free;
    assign in_accept = i_valid && !o_stall;

    // Saturate the requested count
    assign want = (i_read_count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : i_read_count;

    // Sequencer and pointer update
    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_fill      = r_fill;
        n_rd_open   = r_rd_open;
        n_wr_open   = r_wr_open;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_dvalid    = r_dvalid;
        n_last      = r_last;
        n_level     = r_level;
        ram_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    // default single result: ok, no byte, last
                    n_out_valid = 1'b1;
                    n_status    = STS_OK;
                    n_rdata     = '0;
                    n_dvalid    = 1'b0;
                    n_last      = 1'b1;
                    priority if (i_action == ACT_OPEN) begin
                        n_rd_ptr  = '0;
                        n_wr_ptr  = '0;
                        n_fill    = '0;
                        n_rd_open = 1'b1;
                        n_wr_open = 1'b1;
                    end else if (i_action > ACT_CLOSE_WR || !(r_rd_open || r_wr_open)) begin
                        n_status = STS_BADF;
                    end else if (i_action == ACT_WRITE) begin
                        if (!r_rd_open) begin
                            n_status = STS_BROKEN;
                        end else if (r_fill == FW'(DEPTH)) begin
                            n_status = STS_BLOCK;
                        end else begin
                            ram_we   = 1'b1;
                            n_wr_ptr = ring_next(r_wr_ptr);
                            n_fill   = r_fill + FW'(1);
                        end
                    end else if (i_action == ACT_READ) begin
                        if (r_fill == '0) begin
                            n_status = r_wr_open ? STS_BLOCK : STS_EOF;
                        end else if (want != '0) begin
                            // bytes follow from the RAM, one per cycle while the output does not stall
                            n_out_valid = r_out_valid && i_stall;
                            n_status    = r_status;
                            n_rdata     = r_rdata;
                            n_dvalid    = r_dvalid;
                            n_last      = r_last;
                            n_state     = S_READ;
                            if (32'(want) < 32'(r_fill)) begin
                                n_left = want;
                            end else begin
                                n_left = COUNT_W'(r_fill);
                            end
                        end
                    end else begin
                        // close one end; last close empties the ring
                        if (i_action == ACT_CLOSE_RD) begin
                            n_rd_open = 1'b0;
                        end else begin
                            n_wr_open = 1'b0;
                        end
                        if ((i_action == ACT_CLOSE_RD || !r_rd_open) &&
                            (i_action == ACT_CLOSE_WR || !r_wr_open)) begin
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                            n_fill   = '0;
                        end
                    end
                end
            end
            S_READ: begin
                // RAM data holds the byte at the read pointer
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = STS_OK;
                    n_rdata     = ram_rdata;
                    n_dvalid    = 1'b1;
                    n_last      = (r_left == COUNT_W'(1));
                    n_rd_ptr    = ring_next(r_rd_ptr);
                    n_fill      = r_fill - FW'(1);
                    n_left      = r_left - COUNT_W'(1);
                    if (r_left == COUNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // level reported with each new result
        n_level = n_out_valid && !(r_out_valid && i_stall) ? n_fill : r_level;
    end

    // State, pointers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_rd_open   <= 1'b0;
            r_wr_open   <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_fill      <= n_fill;
            r_rd_open   <= n_rd_open;
            r_wr_open   <= n_wr_open;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_dvalid <= n_dvalid;
        r_last   <= n_last;
        r_level  <= n_level;
    end

    // Ring storage; read address is the next pointer so data tracks r_rd_ptr
    pbf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_write_data),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign level_ext    = 32'(r_level);
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_read_data  = r_rdata;
    assign o_data_valid = r_dvalid;
    assign o_last       = r_last;
    assign o_fill_level = level_ext[LEVEL_W-1:0];

endmodule
